FILE: sv/fdp_pkg.sv
// ----------------------------------------------------------------------------
// fdp_pkg
// shared widths, types and controller codes for the frame deadline pacer
// ----------------------------------------------------------------------------
package fdp_pkg;

  // fraction bits of the unsigned fixed-point schedule values
  localparam int unsigned FRACTION_BITS = 16;

  localparam int unsigned FX_W   = 64;
  localparam int unsigned TS_W   = 48;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned TICK_W = 32;
  localparam int unsigned PROD_W = TICK_W + RATE_W;
  localparam int unsigned CUR_W  = TS_W + FRACTION_BITS;

  // the shared divider must hold both the scaled product and a 64-bit lateness
  localparam int unsigned DVD_W  = (PROD_W + FRACTION_BITS > FX_W) ?
                                   PROD_W + FRACTION_BITS : FX_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W);

  typedef logic [FX_W-1:0]   fx_t;
  typedef logic [FX_W:0]     fxc_t;
  typedef logic [TS_W-1:0]   ts_t;
  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [CUR_W-1:0]  cur_t;
  typedef logic [DVD_W-1:0]  dvd_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam fx_t FX_MAX = '1;
  localparam ts_t TS_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1,
    ST_PER,
    ST_EVAL,
    ST_DIV2,
    ST_ALIGN,
    ST_PUSH
  } fdp_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic per;
    logic eval;
    logic align;
    logic push;
  } fdp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic disabled;
    logic div_busy;
    logic go_div2;
    logic out_free;
  } fdp_sts_t;

endpackage

FILE: sv/fdp_if.sv
// ----------------------------------------------------------------------------
// fdp_if
// valid/ready channels for pacer requests and results
// ----------------------------------------------------------------------------
interface fdp_req_if;
  logic                 valid;
  logic                 ready;
  fdp_pkg::ts_t         now_ticks;
  fdp_pkg::rate_t       rate_num;
  fdp_pkg::rate_t       rate_den;
  logic                 align_after_miss;

  modport source (
    output valid, now_ticks, rate_num, rate_den, align_after_miss,
    input  ready
  );
  modport sink (
    input  valid, now_ticks, rate_num, rate_den, align_after_miss,
    output ready
  );
endinterface

interface fdp_res_if;
  logic                 valid;
  logic                 ready;
  logic                 has_deadline;
  fdp_pkg::ts_t         deadline_ticks;

  modport source (
    output valid, has_deadline, deadline_ticks,
    input  ready
  );
  modport sink (
    input  valid, has_deadline, deadline_ticks,
    output ready
  );
endinterface

FILE: sv/fdp_div.sv
// ----------------------------------------------------------------------------
// fdp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fdp_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  fdp_pkg::dvd_t  dividend_i,
  input  fdp_pkg::fx_t   divisor_i,
  output logic           busy_o,
  output fdp_pkg::dvd_t  quotient_o,
  output fdp_pkg::fx_t   remainder_o
);

  logic          busy_q;
  fdp_pkg::cnt_t cnt_q;
  fdp_pkg::dvd_t quo_q, quo_d;
  fdp_pkg::fx_t  rem_q, rem_d;
  fdp_pkg::fx_t  dvs_q;
  fdp_pkg::fxc_t rem_sh, rem_sub;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[fdp_pkg::DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[fdp_pkg::FX_W-1:0] : rem_sh[fdp_pkg::FX_W-1:0];
    quo_d   = {quo_q[fdp_pkg::DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= fdp_pkg::cnt_t'(fdp_pkg::DVD_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: sv/fdp_dp.sv
// ----------------------------------------------------------------------------
// fdp_dp
// schedule state, period and deadline arithmetic, result register
// ----------------------------------------------------------------------------
module fdp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  fdp_pkg::tick_t     cfg_wdata_i,
  input  fdp_pkg::fdp_cmd_t  cmd_i,
  output fdp_pkg::fdp_sts_t  sts_o,
  input  fdp_pkg::ts_t       now_ticks_i,
  input  fdp_pkg::rate_t     rate_num_i,
  input  fdp_pkg::rate_t     rate_den_i,
  input  logic               align_after_miss_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic               res_has_deadline_o,
  output fdp_pkg::ts_t       res_deadline_ticks_o
);

  // schedule state
  fdp_pkg::tick_t tick_rate_q;
  fdp_pkg::fx_t   nd_q;
  fdp_pkg::rate_t last_num_q, last_den_q;

  // per-transaction working registers
  fdp_pkg::rate_t num_q, den_q;
  logic           align_q;
  fdp_pkg::prod_t prod_q;
  fdp_pkg::fx_t   cur_q, period_q;
  logic           res_has_q;
  fdp_pkg::ts_t   res_dl_q;

  // output register
  logic           out_valid_q;
  logic           out_has_q;
  fdp_pkg::ts_t   out_dl_q;

  fdp_pkg::cur_t  cur_full;
  fdp_pkg::fx_t   cur_d, per_raw, period_d, p4;
  fdp_pkg::fxc_t  back_sum, rst_sum, adv_sum, al_sum, dl_sum;
  fdp_pkg::fx_t   back_lhs, rst_nd, adv_nd, al_nd;
  fdp_pkg::ts_t   dl_val;
  logic           disabled, missed, back, restart, go_div2, out_free;

  logic           div_start, div_busy;
  fdp_pkg::dvd_t  div_dividend, div_quo;
  fdp_pkg::fx_t   div_divisor, div_rem;

  always_comb begin
    // timestamp into fixed point, saturated
    cur_full = fdp_pkg::cur_t'(now_ticks_i) << fdp_pkg::FRACTION_BITS;
    cur_d    = ((cur_full >> fdp_pkg::FX_W) != '0) ? fdp_pkg::FX_MAX
                                                   : fdp_pkg::fx_t'(cur_full);

    // period from quotient, saturated, never zero
    per_raw  = ((div_quo >> fdp_pkg::FX_W) != '0) ? fdp_pkg::FX_MAX
                                                  : fdp_pkg::fx_t'(div_quo);
    period_d = (per_raw == '0) ? fdp_pkg::fx_t'(1) : per_raw;

    disabled = (tick_rate_q == '0) || (num_q == '0) || (den_q == '0);

    p4       = (period_q[fdp_pkg::FX_W-1 -: 2] != 2'b00) ? fdp_pkg::FX_MAX
                                                         : period_q << 2;
    back_sum = fdp_pkg::fxc_t'(cur_q) + fdp_pkg::fxc_t'(p4);
    back_lhs = back_sum[fdp_pkg::FX_W] ? fdp_pkg::FX_MAX : back_sum[fdp_pkg::FX_W-1:0];
    back     = back_lhs < nd_q;
    missed   = cur_q > nd_q;
    restart  = (num_q != last_num_q) || (den_q != last_den_q) || (nd_q == '0) ||
               back || (missed && !align_q);
    go_div2  = !restart && missed;

    rst_sum  = fdp_pkg::fxc_t'(cur_q) + fdp_pkg::fxc_t'(period_q);
    rst_nd   = rst_sum[fdp_pkg::FX_W] ? fdp_pkg::FX_MAX : rst_sum[fdp_pkg::FX_W-1:0];
    adv_sum  = fdp_pkg::fxc_t'(nd_q) + fdp_pkg::fxc_t'(period_q);
    adv_nd   = adv_sum[fdp_pkg::FX_W] ? fdp_pkg::FX_MAX : adv_sum[fdp_pkg::FX_W-1:0];

    // skipping whole periods lands on cur - (late mod period) + period
    al_sum   = fdp_pkg::fxc_t'(cur_q - div_rem) + fdp_pkg::fxc_t'(period_q);
    al_nd    = al_sum[fdp_pkg::FX_W] ? fdp_pkg::FX_MAX : al_sum[fdp_pkg::FX_W-1:0];

    // round half up to a whole tick
    dl_sum   = fdp_pkg::fxc_t'(nd_q >> fdp_pkg::FRACTION_BITS) +
               fdp_pkg::fxc_t'(nd_q[fdp_pkg::FRACTION_BITS-1]);
    dl_val   = (dl_sum > fdp_pkg::fxc_t'(fdp_pkg::TS_MAX)) ? fdp_pkg::TS_MAX
                                                           : fdp_pkg::ts_t'(dl_sum);

    out_free = !out_valid_q || res_ready_i;

    div_start    = (cmd_i.prep && !disabled) || (cmd_i.eval && go_div2);
    div_dividend = cmd_i.prep ? (fdp_pkg::dvd_t'(prod_q) << fdp_pkg::FRACTION_BITS)
                              : fdp_pkg::dvd_t'(cur_q - nd_q);
    div_divisor  = cmd_i.prep ? fdp_pkg::fx_t'(num_q) : period_q;
  end

  fdp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= '0;
      nd_q        <= '0;
      last_num_q  <= '0;
      last_den_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tick_rate_q <= cfg_wdata_i;
        nd_q        <= '0;
        last_num_q  <= '0;
        last_den_q  <= '0;
      end else if (cmd_i.prep && disabled) begin
        nd_q        <= '0;
        last_num_q  <= '0;
        last_den_q  <= '0;
      end else if (cmd_i.eval && restart) begin
        nd_q        <= rst_nd;
        last_num_q  <= num_q;
        last_den_q  <= den_q;
      end else if (cmd_i.eval && !missed) begin
        nd_q        <= adv_nd;
      end else if (cmd_i.align) begin
        nd_q        <= al_nd;
      end

      if (cmd_i.push && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q   <= rate_num_i;
      den_q   <= rate_den_i;
      align_q <= align_after_miss_i;
      prod_q  <= fdp_pkg::prod_t'(tick_rate_q) * fdp_pkg::prod_t'(rate_den_i);
      cur_q   <= cur_d;
    end
    if (cmd_i.per) begin
      period_q <= period_d;
    end
    if (cmd_i.prep || cmd_i.eval || cmd_i.align) begin
      res_has_q <= cmd_i.eval && !restart && !missed;
      res_dl_q  <= (cmd_i.eval && !restart && !missed) ? dl_val : '0;
    end
    if (cmd_i.push && out_free) begin
      out_has_q <= res_has_q;
      out_dl_q  <= res_dl_q;
    end
  end

  assign sts_o.disabled = disabled;
  assign sts_o.div_busy = div_busy;
  assign sts_o.go_div2  = go_div2;
  assign sts_o.out_free = out_free;

  assign res_valid_o          = out_valid_q;
  assign res_has_deadline_o   = out_has_q;
  assign res_deadline_ticks_o = out_dl_q;

endmodule

FILE: sv/fdp_ctrl.sv
// ----------------------------------------------------------------------------
// fdp_ctrl
// sequencer for one pacer transaction at a time
// ----------------------------------------------------------------------------
module fdp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fdp_pkg::fdp_sts_t  sts_i,
  output fdp_pkg::fdp_cmd_t  cmd_o
);

  fdp_pkg::fdp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      fdp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = fdp_pkg::ST_PREP;
        end
      end
      fdp_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.disabled ? fdp_pkg::ST_PUSH : fdp_pkg::ST_DIV1;
      end
      fdp_pkg::ST_DIV1: begin
        if (!sts_i.div_busy) begin
          state_d = fdp_pkg::ST_PER;
        end
      end
      fdp_pkg::ST_PER: begin
        cmd_o.per = 1'b1;
        state_d   = fdp_pkg::ST_EVAL;
      end
      fdp_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.go_div2 ? fdp_pkg::ST_DIV2 : fdp_pkg::ST_PUSH;
      end
      fdp_pkg::ST_DIV2: begin
        if (!sts_i.div_busy) begin
          state_d = fdp_pkg::ST_ALIGN;
        end
      end
      fdp_pkg::ST_ALIGN: begin
        cmd_o.align = 1'b1;
        state_d     = fdp_pkg::ST_PUSH;
      end
      fdp_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        if (sts_i.out_free) begin
          state_d = fdp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/frame_deadline_pacer.sv
// sequence: a request is loaded in idle, then walks prep, the period division, evaluate and
//   push; a re-aligned miss adds the lateness division and align; disabled goes prep to push
// flow: one request at a time, taken only in idle; the shared radix-2 divider works out a
//   68-bit quotient for the period and another for the lateness remainder; a held result
//   stalls the sequencer in push
// reset: asynchronous active low; tick rate and schedule state clear, no result pending
// ----------------------------------------------------------------------------
// frame_deadline_pacer
// frame-rate limiter: turns timestamped rate requests into wait deadlines
// ----------------------------------------------------------------------------
module frame_deadline_pacer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  fdp_pkg::tick_t  cfg_wdata_i,
  fdp_req_if.sink         req_i,
  fdp_res_if.source       res_o
);

  // command and status between the sequencer and the datapath
  fdp_pkg::fdp_cmd_t cmd;
  fdp_pkg::fdp_sts_t sts;

  // the sequencer takes a request transaction only from idle, then walks
  // prep -> period division -> evaluate -> (lateness division -> align) -> push
  fdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath holds the tick rate, the Q48.16 next deadline and the last rate;
  // the result register lets a new request in while a result still waits
  fdp_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .now_ticks_i          (req_i.now_ticks),
    .rate_num_i           (req_i.rate_num),
    .rate_den_i           (req_i.rate_den),
    .align_after_miss_i   (req_i.align_after_miss),
    .res_valid_o          (res_o.valid),
    .res_ready_i          (res_o.ready),
    .res_has_deadline_o   (res_o.has_deadline),
    .res_deadline_ticks_o (res_o.deadline_ticks)
  );

  // only one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while another is in flight");

  // a push into a free result slot must show up as a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push && sts.out_free |=> res_o.valid)
    else $error("pushed result not presented");

  // a result without a deadline carries a zero deadline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.has_deadline |-> res_o.deadline_ticks == '0)
    else $error("deadline ticks nonzero without deadline");

  // the sequencer issues at most one command a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the frame deadline pacer: directed corner requests,
// then phases of random paced request streams under several tick rates, every
// result checked in order against an untimed model of the schedule
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned    F              = fdp_pkg::FRACTION_BITS;
  localparam int unsigned    WATCHDOG_LIMIT = 4000;
  localparam int unsigned    HOLD_AFTER     = 300;
  localparam int unsigned    HOLD_CYCLES    = 400;
  localparam int unsigned    TAIL_CYCLES    = 200;
  localparam int unsigned    PHASE_ITEMS    = 260;
  localparam fdp_pkg::rate_t RATE_MAX       = '1;

  // one expected result transaction
  typedef struct packed {
    logic         has_deadline;
    fdp_pkg::ts_t deadline_ticks;
  } deadline_t;

  // schedule model plus the queue of deadlines still owed by the block
  class deadline_scoreboard;
    fdp_pkg::tick_t tick_rate = '0;
    fdp_pkg::fx_t   next_dl   = '0;
    fdp_pkg::rate_t sched_num = '0;
    fdp_pkg::rate_t sched_den = '0;
    deadline_t      expected_q[$];
    int unsigned    errors = 0;

    function void clear_schedule();
      next_dl   = '0;
      sched_num = '0;
      sched_den = '0;
    endfunction

    function void write_tick_rate(fdp_pkg::tick_t v);
      tick_rate = v;
      clear_schedule();
    endfunction

    function fdp_pkg::fx_t sat_add(fdp_pkg::fx_t a, fdp_pkg::fx_t b);
      fdp_pkg::fxc_t s;
      s = {1'b0, a} + {1'b0, b};
      return s[fdp_pkg::FX_W] ? fdp_pkg::FX_MAX : s[fdp_pkg::FX_W-1:0];
    endfunction

    function fdp_pkg::fx_t sat_mul(fdp_pkg::fx_t a, fdp_pkg::fx_t b);
      logic [2*fdp_pkg::FX_W-1:0] p;
      p = {{fdp_pkg::FX_W{1'b0}}, a} * {{fdp_pkg::FX_W{1'b0}}, b};
      return (|p[2*fdp_pkg::FX_W-1:fdp_pkg::FX_W]) ? fdp_pkg::FX_MAX
                                                   : p[fdp_pkg::FX_W-1:0];
    endfunction

    // frame period in fixed point, tick_rate*den/num
    function fdp_pkg::fx_t period_of(fdp_pkg::rate_t num, fdp_pkg::rate_t den);
      logic [127:0] prod, quo, rem, whole;
      fdp_pkg::fx_t whole_fx, frac, p;
      if (tick_rate == '0 || num == '0 || den == '0) return '0;
      prod     = 128'(tick_rate) * 128'(den);
      quo      = prod / 128'(num);
      rem      = prod % 128'(num);
      whole    = quo << F;
      whole_fx = (|whole[127:fdp_pkg::FX_W]) ? fdp_pkg::FX_MAX : whole[fdp_pkg::FX_W-1:0];
      frac     = fdp_pkg::fx_t'((rem << F) / 128'(num));
      p        = sat_add(whole_fx, frac);
      if (p == '0) p = fdp_pkg::fx_t'(1);
      return p;
    endfunction

    function void note_request(fdp_pkg::ts_t now, fdp_pkg::rate_t num,
                               fdp_pkg::rate_t den, logic align_miss);
      fdp_pkg::fx_t  period, cur, skipped;
      fdp_pkg::fxc_t rounded;
      logic          missed, back;
      deadline_t     res;
      res = '0;
      if (tick_rate == '0 || num == '0 || den == '0) begin
        clear_schedule();
        expected_q.push_back(res);
        return;
      end
      period = period_of(num, den);
      cur    = (fdp_pkg::fx_t'(now) > (fdp_pkg::FX_MAX >> F)) ? fdp_pkg::FX_MAX
                                                             : (fdp_pkg::fx_t'(now) << F);
      missed = cur > next_dl;
      back   = sat_add(cur, sat_mul(period, fdp_pkg::fx_t'(4))) < next_dl;
      if (sched_num != num || sched_den != den || next_dl == '0 || back ||
          (missed && !align_miss)) begin
        sched_num = num;
        sched_den = den;
        next_dl   = sat_add(cur, period);
      end else if (missed) begin
        skipped = (cur - next_dl) / period + fdp_pkg::fx_t'(1);
        next_dl = sat_add(next_dl, sat_mul(skipped, period));
      end else begin
        rounded              = fdp_pkg::fxc_t'(next_dl >> F) + fdp_pkg::fxc_t'(next_dl[F-1]);
        res.has_deadline     = 1'b1;
        res.deadline_ticks   = (rounded > fdp_pkg::fxc_t'(fdp_pkg::TS_MAX)) ?
                               fdp_pkg::TS_MAX : fdp_pkg::ts_t'(rounded);
        next_dl              = sat_add(next_dl, period);
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic has_dl, fdp_pkg::ts_t dl_ticks);
      deadline_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, flag %0b deadline %0d",
                 $time, has_dl, dl_ticks);
        return;
      end
      exp_res = expected_q.pop_front();
      if (has_dl !== exp_res.has_deadline) begin
        errors++;
        $display("%0t: has_deadline mismatch, expected %0b, actual %0b",
                 $time, exp_res.has_deadline, has_dl);
      end
      if (dl_ticks !== exp_res.deadline_ticks) begin
        errors++;
        $display("%0t: deadline_ticks mismatch, expected %0d, actual %0d",
                 $time, exp_res.deadline_ticks, dl_ticks);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  logic           cfg_we;
  fdp_pkg::tick_t cfg_wdata;

  fdp_req_if req_if ();
  fdp_res_if res_if ();

  deadline_scoreboard sb = new();

  // idle burst likelihood, set per phase; zero gives stretches with no gaps
  int unsigned    idle_pct     = 0;
  int unsigned    results_seen = 0;
  fdp_pkg::rate_t stream_num;
  fdp_pkg::rate_t stream_den;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frame_deadline_pacer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  // result side: every accepted transaction goes to the scoreboard
  always @(posedge clk) begin
    if (res_if.valid && res_if.ready) begin
      sb.check_result(res_if.has_deadline, res_if.deadline_ticks);
      results_seen++;
    end
  end

  // result ready: random stall bursts, plus one long hold-off once some
  // results have gone by, so the block backs up and stalls its request side
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_done;
    stall_left    = 0;
    hold_done     = 1'b0;
    res_if.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          hold_done  = 1'b1;
          stall_left = HOLD_CYCLES;
        end else if ($urandom_range(0, 399) < idle_pct) begin
          stall_left = $urandom_range(1, 16);
        end
      end
      if (stall_left != 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  // run ends in failure if no transaction moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // offer one request, optionally after an idle burst; valid stays high on
  // return so back-to-back requests need no extra cycle
  task automatic send_request(fdp_pkg::ts_t now, fdp_pkg::rate_t num,
                              fdp_pkg::rate_t den, logic align_miss);
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid = 1'b0;
      gap          = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    req_if.now_ticks        = now;
    req_if.rate_num         = num;
    req_if.rate_den         = den;
    req_if.align_after_miss = align_miss;
    req_if.valid            = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(now, num, den, align_miss);
    @(negedge clk);
  endtask

  // tick rate is only written with the block drained
  task automatic set_tick_rate(fdp_pkg::tick_t v);
    req_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    sb.write_tick_rate(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly video-like rates, some fully random, some with huge or tiny periods
  task automatic pick_rate(output fdp_pkg::rate_t num, output fdp_pkg::rate_t den);
    case ($urandom_range(0, 9))
      6: begin
        num = fdp_pkg::rate_t'($urandom_range(1000, 60000));
        den = fdp_pkg::rate_t'($urandom_range(1000, 1001));
      end
      7: begin
        num = fdp_pkg::rate_t'($urandom_range(1, (1 << fdp_pkg::RATE_W) - 1));
        den = fdp_pkg::rate_t'($urandom_range(1, (1 << fdp_pkg::RATE_W) - 1));
      end
      8: begin
        num = fdp_pkg::rate_t'($urandom_range(1, 16));
        den = fdp_pkg::rate_t'($urandom_range(1, (1 << fdp_pkg::RATE_W) - 1));
      end
      9: begin
        num = RATE_MAX;
        den = 20'd1;
      end
      default: begin
        num = fdp_pkg::rate_t'($urandom_range(1, 240));
        den = fdp_pkg::rate_t'($urandom_range(1, 4));
      end
    endcase
  endtask

  task automatic directed_requests();
    set_tick_rate(32'd1000);
    send_request(48'd0, 20'd60, 20'd1, 1'b0);     // empty schedule, restart
    send_request(48'd10, 20'd60, 20'd1, 1'b0);    // steady, fraction rounds up
    send_request(48'd20, 20'd60, 20'd1, 1'b1);    // steady, fraction rounds down
    send_request(48'd200, 20'd60, 20'd1, 1'b1);   // missed, phase kept
    send_request(48'd210, 20'd60, 20'd1, 1'b1);
    send_request(48'd5000, 20'd60, 20'd1, 1'b0);  // missed, schedule restarts
    send_request(48'd100, 20'd60, 20'd1, 1'b0);   // clock went far backwards
    send_request(48'd101, 20'd30, 20'd1, 1'b0);   // new rate
    send_request(48'd102, 20'd30, 20'd1, 1'b0);
    send_request(48'd103, 20'd0, 20'd1, 1'b0);    // zero numerator
    send_request(48'd104, 20'd30, 20'd0, 1'b1);   // zero denominator
    send_request(fdp_pkg::TS_MAX, RATE_MAX, RATE_MAX, 1'b0);
    send_request(fdp_pkg::TS_MAX, RATE_MAX, RATE_MAX, 1'b1); // deadline clamps at the top
    send_request(fdp_pkg::TS_MAX, RATE_MAX, RATE_MAX, 1'b1);
    set_tick_rate(32'd1);
    send_request(48'd7, RATE_MAX, 20'd1, 1'b0);   // period rounds to nothing
    send_request(48'd7, RATE_MAX, 20'd1, 1'b1);
    set_tick_rate(32'd0);
    send_request(48'd5, 20'd60, 20'd1, 1'b0);     // scheduling switched off
    set_tick_rate(32'hFFFF_FFFF);
    send_request(48'd0, 20'd1, RATE_MAX, 1'b0);   // period saturates
    send_request(48'd1, 20'd1, RATE_MAX, 1'b1);
    send_request(48'h5555_5555_5555, 20'hAAAAA, 20'h55555, 1'b1);
    send_request(48'hAAAA_AAAA_AAAA, 20'h55555, 20'hAAAAA, 1'b0);
  endtask

  // one tick rate, a paced stream that mostly lands inside the deadline
  // window, salted with misses, time jumps, rate changes and junk requests
  task automatic run_phase(fdp_pkg::tick_t rate, int unsigned n, int unsigned pct);
    int unsigned    kind;
    fdp_pkg::ts_t   now;
    fdp_pkg::ts_t   base;
    fdp_pkg::rate_t num, den;
    logic           aln;
    logic [127:0]   t, per_ticks, next_ticks, delta;
    set_tick_rate(rate);
    idle_pct = pct;
    pick_rate(stream_num, stream_den);
    case ($urandom_range(0, 9))
      7, 8:    base = fdp_pkg::ts_t'({$urandom, $urandom});
      9:       base = fdp_pkg::TS_MAX - fdp_pkg::ts_t'($urandom_range(0, 1000));
      default: base = fdp_pkg::ts_t'($urandom);
    endcase
    for (int i = 0; i < n; i++) begin
      num        = stream_num;
      den        = stream_den;
      aln        = 1'($urandom_range(0, 1));
      per_ticks  = 128'(sb.period_of(num, den)) >> F;
      next_ticks = 128'(sb.next_dl) >> F;
      delta      = 128'({$urandom, $urandom}) % (per_ticks + 128'd1);
      kind       = $urandom_range(0, 99);
      if (kind < 70) begin
        // within one period ahead of the deadline
        if (sb.next_dl == '0) t = 128'(base);
        else t = (next_ticks >= delta) ? next_ticks - delta : 128'd0;
      end else if (kind < 78) begin
        t   = next_ticks + 128'd1 + delta * 128'($urandom_range(0, 3));
        aln = 1'b1;
      end else if (kind < 83) begin
        t   = next_ticks + 128'd1 + delta;
        aln = 1'b0;
      end else if (kind < 86) begin
        // more than four periods back
        if (next_ticks > 128'd5 * per_ticks + 128'd1) begin
          t = next_ticks - 128'd5 * per_ticks - 128'd1;
        end else begin
          t = 128'd0;
        end
      end else if (kind < 90) begin
        pick_rate(stream_num, stream_den);
        num = stream_num;
        den = stream_den;
        t   = next_ticks;
      end else if (kind < 96) begin
        num = fdp_pkg::rate_t'($urandom_range(0, (1 << fdp_pkg::RATE_W) - 1));
        den = fdp_pkg::rate_t'($urandom_range(0, (1 << fdp_pkg::RATE_W) - 1));
        t   = 128'(fdp_pkg::ts_t'({$urandom, $urandom}));
      end else begin
        if ($urandom_range(0, 1) == 0) num = '0;
        else den = '0;
        t = next_ticks;
      end
      now = (t > 128'(fdp_pkg::TS_MAX)) ? fdp_pkg::TS_MAX : t[fdp_pkg::TS_W-1:0];
      send_request(now, num, den, aln);
    end
  endtask

  initial begin : main
    req_if.valid            = 1'b0;
    req_if.now_ticks        = '0;
    req_if.rate_num         = '0;
    req_if.rate_den         = '0;
    req_if.align_after_miss = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    rst_n                   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_requests();

    // last phase runs without gaps on either side
    run_phase(32'd90000, PHASE_ITEMS, 20);
    run_phase(32'd48000, PHASE_ITEMS, 0);
    run_phase(32'd1000000, PHASE_ITEMS, 40);
    run_phase(32'hFFFF_FFFF, PHASE_ITEMS, 10);
    run_phase(fdp_pkg::tick_t'($urandom), PHASE_ITEMS, 30);
    run_phase(32'd1, PHASE_ITEMS, 60);
    run_phase(32'd90000, PHASE_ITEMS, 0);

    req_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/fdp_pkg.sv
sv/fdp_if.sv
sv/fdp_div.sv
sv/fdp_dp.sv
sv/fdp_ctrl.sv
sv/frame_deadline_pacer.sv
test/testbench.sv
